[src/uartq_pkg.sv]
`default_nettype none

package uartq_pkg;

  localparam int unsigned TxDepth = 1024;
  localparam int unsigned RxDepth = 64;
  localparam int unsigned TxPtrW  = $clog2(TxDepth);
  localparam int unsigned RxPtrW  = $clog2(RxDepth);
  // Capacity register widths, one bit wider than the pointers so the depth fits
  localparam int unsigned TxCapW  = 11;
  localparam int unsigned RxCapW  = 7;
  localparam int unsigned MinCap  = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  typedef enum logic [2:0] {
    KindTxPush  = 3'd0,
    KindTxEmpty = 3'd1,
    KindRxByte  = 3'd2,
    KindRxPop   = 3'd3,
    KindRxClear = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    RegTxCap = 1'b0,
    RegRxCap = 1'b1
  } reg_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       parity_error;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic [7:0]        popped_byte;
    logic [7:0]        head_byte;
    logic [RxPtrW-1:0] rx_count;
    logic              tx_irq_enable;
    logic              dropped;
  } out_item_t;

  typedef struct packed {
    logic [TxCapW-1:0] tx_cap;
    logic [RxCapW-1:0] rx_cap;
    logic              tx_wr;
    logic              rx_wr;
  } cfg_t;

endpackage

`default_nettype wire

[src/uartq_intf.sv]
`default_nettype none

interface uartq_in_if;
  import uartq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uartq_out_if;
  import uartq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/uartq_ram.sv]
`default_nettype none

module uartq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/uartq_cfg.sv]
`default_nettype none

module uartq_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [uartq_pkg::AddrW-1:0]     paddr,
  input  wire logic [uartq_pkg::DataW-1:0]     pwdata,
  output logic      [uartq_pkg::DataW-1:0]     prdata,
  output logic                                 pready,
  output uartq_pkg::cfg_t                      cfg_o
);
  import uartq_pkg::*;

  logic [TxCapW-1:0] tx_cap_q, tx_cap_d, tx_val;
  logic [RxCapW-1:0] rx_cap_q, rx_cap_d, rx_val;
  logic              wr;
  reg_e              sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[2]);
  assign tx_val = pwdata[TxCapW-1:0];
  assign rx_val = pwdata[RxCapW-1:0];

  // Zero means no buffer; small values round up, large ones clamp to the store
  always_comb begin
    if (tx_val == '0) begin
      tx_cap_d = '0;
    end else if (tx_val < TxCapW'(MinCap)) begin
      tx_cap_d = TxCapW'(MinCap);
    end else if (tx_val > TxCapW'(TxDepth)) begin
      tx_cap_d = TxCapW'(TxDepth);
    end else begin
      tx_cap_d = tx_val;
    end
    if (rx_val == '0) begin
      rx_cap_d = '0;
    end else if (rx_val < RxCapW'(MinCap)) begin
      rx_cap_d = RxCapW'(MinCap);
    end else if (rx_val > RxCapW'(RxDepth)) begin
      rx_cap_d = RxCapW'(RxDepth);
    end else begin
      rx_cap_d = rx_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cap_q <= '0;
      rx_cap_q <= '0;
    end else if (wr) begin
      unique case (sel)
        RegTxCap: tx_cap_q <= tx_cap_d;
        RegRxCap: rx_cap_q <= rx_cap_d;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegTxCap: prdata = DataW'(tx_cap_q);
      RegRxCap: prdata = DataW'(rx_cap_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.tx_cap = tx_cap_q;
  assign cfg_o.rx_cap = rx_cap_q;
  assign cfg_o.tx_wr  = wr && (sel == RegTxCap);
  assign cfg_o.rx_wr  = wr && (sel == RegRxCap);

endmodule

`default_nettype wire

[src/uart_buffered_tx_rx_queues_top.sv]
// Pipeline: each input word passes through the stage-one register, then the output
// register; stage one holds its word while the output register waits on res_o.
// Throughput: one word per cycle unless res_o stalls; the registered byte-store read
// sets the two-stage depth, and the output register holds a waiting result.
// Reset: pointers, interrupt enable and both capacities go to zero (no buffer);
// the byte stores are not cleared and need no clearing pass.
`default_nettype none

module uart_buffered_tx_rx_queues_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  uartq_in_if.sink                         item_i,
  uartq_out_if.source                      res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uartq_pkg::AddrW-1:0] paddr,
  input  wire logic [uartq_pkg::DataW-1:0] pwdata,
  output logic      [uartq_pkg::DataW-1:0] prdata,
  output logic                             pready
);
  import uartq_pkg::*;

  typedef struct packed {
    logic              send;
    logic              pop_ne;
    logic              head_ne;
    logic              byp;
    logic [7:0]        byp_byte;
    logic [RxPtrW-1:0] rx_count;
    logic              irq;
    logic              dropped;
  } s1_t;

  function automatic logic [TxPtrW-1:0] tx_adv(input logic [TxPtrW-1:0] p,
                                               input logic [TxCapW-1:0] cap);
    logic [TxCapW-1:0] n;
    n = TxCapW'(p) + TxCapW'(1);
    return (n >= cap) ? '0 : n[TxPtrW-1:0];
  endfunction

  function automatic logic [RxPtrW-1:0] rx_adv(input logic [RxPtrW-1:0] p,
                                               input logic [RxCapW-1:0] cap);
    logic [RxCapW-1:0] n;
    n = RxCapW'(p) + RxCapW'(1);
    return (n >= cap) ? '0 : n[RxPtrW-1:0];
  endfunction

  cfg_t cfg;

  logic [TxPtrW-1:0] tx_head_q, tx_head_d, tx_head_n;
  logic [TxPtrW-1:0] tx_tail_q, tx_tail_d, tx_tail_n;
  logic [RxPtrW-1:0] rx_head_q, rx_head_d, rx_head_n;
  logic [RxPtrW-1:0] rx_tail_q, rx_tail_d, rx_tail_n;
  logic              irq_q, irq_d, irq_n;

  logic              in_acc, s1_adv;
  logic              tx_we, rx_we, send, pop_ne, drop;
  logic [RxCapW-1:0] cnt_wide;
  logic [RxPtrW-1:0] cnt;

  logic              s1_valid_q, s1_valid_d;
  s1_t               s1_q, s1_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [7:0]        last_head_q;
  logic [7:0]        head_now;

  logic [7:0]        tx_rdata, rx_rdata;

  uartq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage advance: stage one moves on when the output register is free
  assign s1_adv       = s1_valid_q && (!out_valid_q || res_o.ready);
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_acc       = item_i.valid && item_i.ready;

  always_comb begin
    tx_head_n = tx_head_q;
    tx_tail_n = tx_tail_q;
    rx_head_n = rx_head_q;
    rx_tail_n = rx_tail_q;
    irq_n     = irq_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    send      = 1'b0;
    pop_ne    = 1'b0;
    drop      = 1'b0;
    unique case (kind_e'(item_i.data.kind))
      KindTxPush: begin
        if (cfg.tx_cap == '0) begin
          drop = 1'b1;
        end else if (tx_adv(tx_tail_q, cfg.tx_cap) == tx_head_q) begin
          drop  = 1'b1;
          irq_n = 1'b1;
        end else begin
          tx_we     = 1'b1;
          tx_tail_n = tx_adv(tx_tail_q, cfg.tx_cap);
          irq_n     = 1'b1;
        end
      end
      KindTxEmpty: begin
        if (cfg.tx_cap == '0 || tx_head_q == tx_tail_q) begin
          irq_n = 1'b0;
        end else begin
          send      = 1'b1;
          tx_head_n = tx_adv(tx_head_q, cfg.tx_cap);
        end
      end
      KindRxByte: begin
        if (item_i.data.parity_error || cfg.rx_cap == '0 ||
            rx_adv(rx_tail_q, cfg.rx_cap) == rx_head_q) begin
          drop = 1'b1;
        end else begin
          rx_we     = 1'b1;
          rx_tail_n = rx_adv(rx_tail_q, cfg.rx_cap);
        end
      end
      KindRxPop: begin
        if (cfg.rx_cap != '0 && rx_head_q != rx_tail_q) begin
          pop_ne    = 1'b1;
          rx_head_n = rx_adv(rx_head_q, cfg.rx_cap);
        end
      end
      KindRxClear: begin
        rx_head_n = '0;
        rx_tail_n = '0;
      end
      default: ;
    endcase
  end

  // Fill level after the step, modulo the capacity
  always_comb begin
    cnt_wide = RxCapW'(rx_tail_n) + cfg.rx_cap - RxCapW'(rx_head_n);
    if (cfg.rx_cap == '0) begin
      cnt = '0;
    end else if (rx_tail_n >= rx_head_n) begin
      cnt = rx_tail_n - rx_head_n;
    end else begin
      cnt = cnt_wide[RxPtrW-1:0];
    end
  end

  // A capacity write empties its queue
  assign tx_head_d = cfg.tx_wr ? '0 : (in_acc ? tx_head_n : tx_head_q);
  assign tx_tail_d = cfg.tx_wr ? '0 : (in_acc ? tx_tail_n : tx_tail_q);
  assign rx_head_d = cfg.rx_wr ? '0 : (in_acc ? rx_head_n : rx_head_q);
  assign rx_tail_d = cfg.rx_wr ? '0 : (in_acc ? rx_tail_n : rx_tail_q);
  assign irq_d     = in_acc ? irq_n : irq_q;

  uartq_ram #(
    .Width (8),
    .Depth (TxDepth)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && tx_we),
    .waddr_i (tx_tail_q),
    .wdata_i (item_i.data.data_byte),
    .re_i    (in_acc),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  uartq_ram #(
    .Width (8),
    .Depth (RxDepth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && rx_we),
    .waddr_i (rx_tail_q),
    .wdata_i (item_i.data.data_byte),
    .re_i    (in_acc),
    .raddr_i (rx_head_n),
    .rdata_o (rx_rdata)
  );

  always_comb begin
    s1_d.send     = send;
    s1_d.pop_ne   = pop_ne;
    s1_d.head_ne  = (cfg.rx_cap != '0) && (rx_head_n != rx_tail_n);
    // New head is the slot written by this same word: forward the byte
    s1_d.byp      = rx_we && (rx_tail_q == rx_head_n);
    s1_d.byp_byte = item_i.data.data_byte;
    s1_d.rx_count = cnt;
    s1_d.irq      = irq_n;
    s1_d.dropped  = drop;
  end

  assign s1_valid_d = in_acc || (s1_valid_q && !s1_adv);

  assign head_now = !s1_q.head_ne ? 8'h00 : (s1_q.byp ? s1_q.byp_byte : rx_rdata);

  // A pop returns the head reported by the word before it
  always_comb begin
    out_d.send_valid    = s1_q.send;
    out_d.send_byte     = s1_q.send ? tx_rdata : 8'h00;
    out_d.popped_byte   = s1_q.pop_ne ? last_head_q : 8'h00;
    out_d.head_byte     = head_now;
    out_d.rx_count      = s1_q.rx_count;
    out_d.tx_irq_enable = s1_q.irq;
    out_d.dropped       = s1_q.dropped;
  end

  assign out_valid_d = s1_adv || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      irq_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      irq_q       <= irq_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q       <= out_d;
      last_head_q <= head_now;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

`default_nettype wire

[tb/uartq_queue_checker.sv]
module uartq_queue_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  uartq_in_if                         item_if,
  uartq_out_if                        res_if,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [uartq_pkg::AddrW-1:0] paddr_i,
  input  logic [uartq_pkg::DataW-1:0] pwdata_i,
  output int unsigned                 fail_cnt_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import uartq_pkg::*;

  logic [7:0]        tx_bytes [TxDepth];
  logic [7:0]        rx_bytes [RxDepth];
  logic [TxPtrW-1:0] tx_rd = '0;
  logic [TxPtrW-1:0] tx_wr = '0;
  logic [RxPtrW-1:0] rx_rd = '0;
  logic [RxPtrW-1:0] rx_wr = '0;
  logic [TxCapW-1:0] tx_slots = '0;
  logic [RxCapW-1:0] rx_slots = '0;
  logic              tx_irq_en = 1'b0;
  out_item_t         status_q [$];
  int unsigned       mismatches = 0;

  assign fail_cnt_o = mismatches;

  function automatic int unsigned slots_for(int unsigned value, int unsigned depth);
    if (value == 0) return 0;
    if (value < MinCap) return MinCap;
    return (value > depth) ? depth : value;
  endfunction

  function automatic int unsigned ring_next(int unsigned ptr, int unsigned slots);
    return (ptr + 1 >= slots) ? 0 : ptr + 1;
  endfunction

  function automatic logic [7:0] rx_front();
    return (rx_slots != 0 && rx_rd != rx_wr) ? rx_bytes[rx_rd] : 8'h00;
  endfunction

  // Apply one word to the mirrored queues and return the status it should produce
  function automatic out_item_t queue_step(in_item_t w);
    out_item_t r;
    r = '0;
    case (w.kind)
      KindTxPush: begin
        if (tx_slots == 0) begin
          r.dropped = 1'b1;
        end else if (ring_next(tx_wr, tx_slots) == tx_rd) begin
          r.dropped = 1'b1;
          tx_irq_en = 1'b1;
        end else begin
          tx_bytes[tx_wr] = w.data_byte;
          tx_wr = TxPtrW'(ring_next(tx_wr, tx_slots));
          tx_irq_en = 1'b1;
        end
      end
      KindTxEmpty: begin
        if (tx_slots == 0 || tx_rd == tx_wr) begin
          tx_irq_en = 1'b0;
        end else begin
          r.send_valid = 1'b1;
          r.send_byte = tx_bytes[tx_rd];
          tx_rd = TxPtrW'(ring_next(tx_rd, tx_slots));
        end
      end
      KindRxByte: begin
        if (w.parity_error || rx_slots == 0 || ring_next(rx_wr, rx_slots) == rx_rd) begin
          r.dropped = 1'b1;
        end else begin
          rx_bytes[rx_wr] = w.data_byte;
          rx_wr = RxPtrW'(ring_next(rx_wr, rx_slots));
        end
      end
      KindRxPop: begin
        if (rx_slots != 0 && rx_rd != rx_wr) begin
          r.popped_byte = rx_front();
          rx_rd = RxPtrW'(ring_next(rx_rd, rx_slots));
        end
      end
      KindRxClear: begin
        rx_rd = '0;
        rx_wr = '0;
      end
      default: ;
    endcase
    r.head_byte = rx_front();
    r.rx_count = (rx_slots == 0) ? '0 :
                 RxPtrW'((32'(rx_slots) + rx_wr - rx_rd) % rx_slots);
    r.tx_irq_enable = tx_irq_en;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      tx_rd = '0;
      tx_wr = '0;
      rx_rd = '0;
      rx_wr = '0;
      tx_slots = '0;
      rx_slots = '0;
      tx_irq_en = 1'b0;
      status_q.delete();
      pending_o = 0;
    end else begin
      // Retire first: a result can never belong to a word taken at the same edge
      if (res_if.valid && res_if.ready) begin
        if (status_q.size() == 0) begin
          $error("result word with no input word waiting");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("send_valid", want.send_valid, res_if.data.send_valid);
          check_field("send_byte", want.send_byte, res_if.data.send_byte);
          check_field("popped_byte", want.popped_byte, res_if.data.popped_byte);
          check_field("head_byte", want.head_byte, res_if.data.head_byte);
          check_field("rx_count", want.rx_count, res_if.data.rx_count);
          check_field("tx_irq_enable", want.tx_irq_enable, res_if.data.tx_irq_enable);
          check_field("dropped", want.dropped, res_if.data.dropped);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[AddrW-1:2]))
          RegTxCap: begin
            tx_slots = TxCapW'(slots_for(pwdata_i[TxCapW-1:0], TxDepth));
            tx_rd = '0;
            tx_wr = '0;
          end
          RegRxCap: begin
            rx_slots = RxCapW'(slots_for(pwdata_i[RxCapW-1:0], RxDepth));
            rx_rd = '0;
            rx_wr = '0;
          end
          default: ;
        endcase
      end
      if (item_if.valid && item_if.ready) begin
        status_q.push_back(queue_step(item_if.data));
      end
      pending_o = status_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import uartq_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned PhaseWords = 75;
  localparam int unsigned NumPhases  = 9;
  localparam logic [2:0]  KindSpareLo = 3'd5;
  localparam logic [2:0]  KindSpareHi = 3'd7;

  typedef enum int unsigned {BiasFill, BiasDrain, BiasMix} bias_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int unsigned      fail_cnt;
  int unsigned      pending;
  int unsigned      quiet_cycles;
  bit               steady_src = 1'b0;
  bit               steady_sink = 1'b0;
  bit               hold_req = 1'b0;

  uartq_in_if  item_if ();
  uartq_out_if res_if ();

  uart_buffered_tx_rx_queues_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  uartq_queue_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_if    (item_if),
    .res_if     (res_if),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t word_of(logic [2:0] kind, logic [7:0] data, logic parity);
    in_item_t w;
    w.kind = kind;
    w.data_byte = data;
    w.parity_error = parity;
    return w;
  endfunction

  // Fill bias mostly adds bytes, drain bias mostly takes them, so full and empty both occur
  function automatic in_item_t make_word(bias_e bias);
    in_item_t w;
    int unsigned roll;
    bit add;
    bit on_tx;
    w.data_byte = 8'($urandom_range(0, 255));
    w.parity_error = ($urandom_range(0, 9) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      w.kind = 3'($urandom_range(KindSpareLo, KindSpareHi));
    end else if (roll < 5) begin
      w.kind = KindRxClear;
    end else begin
      roll = $urandom_range(0, 99);
      add = (bias == BiasFill) ? (roll < 80) : (bias == BiasDrain) ? (roll < 20) : (roll < 50);
      on_tx = $urandom_range(0, 1);
      if (add) w.kind = on_tx ? KindTxPush : KindRxByte;
      else w.kind = on_tx ? KindTxEmpty : KindRxPop;
    end
    return w;
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken
  task automatic push_word(input in_item_t w);
    int unsigned gap = steady_src ? 0 : idle_len();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= w;
    do @(posedge clk); while (!item_if.ready);
    @(negedge clk);
  endtask

  // Drop valid, drain every outstanding result, then allow for the pipeline
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned tx_cap, input int unsigned rx_cap);
    write_reg(RegTxCap, DataW'(tx_cap));
    write_reg(RegRxCap, DataW'(rx_cap));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : sink_side
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HoldCycles;
          hold_req = 1'b0;
        end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 9) ? $urandom_range(8, 40) :
                       $urandom_range(1, 3);
        end
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned tx_set [NumPhases];
    int unsigned rx_set [NumPhases];
    bias_e       bias;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    quiet_cycles = 0;
    bias = BiasMix;
    tx_set = '{16, 17, 1024, 0, 15, 300, 1, 1023, 0};
    rx_set = '{64, 16, 63, 33, 0, 1, 17, 64, 0};
    tx_set[NumPhases-1] = $urandom_range(0, 1024);
    rx_set[NumPhases-1] = $urandom_range(0, 64);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No buffer on either side after reset
    push_word(word_of(KindTxPush, 8'hA5, 1'b0));
    push_word(word_of(KindTxEmpty, 8'h00, 1'b0));
    push_word(word_of(KindRxByte, 8'h5A, 1'b0));
    push_word(word_of(KindRxPop, 8'h00, 1'b0));
    push_word(word_of(KindRxClear, 8'h00, 1'b0));
    push_word(word_of(KindSpareLo, 8'hFF, 1'b1));
    push_word(word_of(KindSpareHi, 8'h00, 1'b0));

    // Smallest non-zero capacities, raised to the minimum
    settle();
    configure(1, 1);
    push_word(word_of(KindRxByte, 8'h00, 1'b0));
    push_word(word_of(KindRxByte, 8'hFF, 1'b0));
    push_word(word_of(KindRxByte, 8'h3C, 1'b1));
    push_word(word_of(KindRxPop, 8'h00, 1'b0));
    push_word(word_of(KindTxPush, 8'hFF, 1'b0));
    push_word(word_of(KindTxPush, 8'h00, 1'b0));
    push_word(word_of(KindTxEmpty, 8'h00, 1'b0));
    push_word(word_of(KindTxEmpty, 8'h00, 1'b0));
    push_word(word_of(KindTxEmpty, 8'h00, 1'b0));
    push_word(word_of(KindRxClear, 8'h00, 1'b0));
    push_word(word_of(KindRxPop, 8'h00, 1'b0));
    push_word(word_of(KindTxPush, 8'h81, 1'b0));

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      configure(tx_set[p], rx_set[p]);
      // Hold the result side off while words keep coming, so the input backs up
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PhaseWords; n++) begin
        if (n % 25 == 0) begin
          bias = bias_e'($urandom_range(0, 2));
          steady_src = ($urandom_range(0, 3) == 0);
          steady_sink = ($urandom_range(0, 3) == 0);
        end
        push_word(make_word(bias));
      end
    end

    settle();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/uartq_pkg.sv
src/uartq_intf.sv
src/uartq_ram.sv
src/uartq_cfg.sv
src/uart_buffered_tx_rx_queues_top.sv
tb/uartq_queue_checker.sv
tb/tb_top.sv
